// ===== design/sha2_pkg.sv =====
// package: shared types, constants and round tables for the sha-2 engine
`default_nettype none
package sha2_pkg;

  typedef enum logic [1:0] {
    VAR_224 = 2'd0,
    VAR_256 = 2'd1,
    VAR_384 = 2'd2,
    VAR_512 = 2'd3
  } variant_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } state_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [1:0] REG_VARIANT = 2'd0;

  // control from the sequencer to the round unit
  typedef struct packed {
    logic       load;   // copy hash into working vars
    logic       step;   // run one round
    logic       wide;
    logic [6:0] rnd;
  } rnd_ctl_t;

  function automatic logic [63:0] round_k(input logic [6:0] t);
    logic [63:0] k;
    unique case (t)
      7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
      7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
      7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
      7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
      7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = 64'h0;
    endcase
    return k;
  endfunction

  function automatic logic [63:0] iv_384(input logic [2:0] i);
    logic [63:0] v;
    unique case (i)
      3'd0: v = 64'hcbbb9d5dc1059ed8; 3'd1: v = 64'h629a292a367cd507;
      3'd2: v = 64'h9159015a3070dd17; 3'd3: v = 64'h152fecd8f70e5939;
      3'd4: v = 64'h67332667ffc00b31; 3'd5: v = 64'h8eb44a8768581511;
      3'd6: v = 64'hdb0c2e0d64f98fa7; default: v = 64'h47b5481dbefa4fa4;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] iv_512(input logic [2:0] i);
    logic [63:0] v;
    unique case (i)
      3'd0: v = 64'h6a09e667f3bcc908; 3'd1: v = 64'hbb67ae8584caa73b;
      3'd2: v = 64'h3c6ef372fe94f82b; 3'd3: v = 64'ha54ff53a5f1d36f1;
      3'd4: v = 64'h510e527fade682d1; 3'd5: v = 64'h9b05688c2b3e6c1f;
      3'd6: v = 64'h1f83d9abfb41bd6b; default: v = 64'h5be0cd19137e2179;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] init_hash(input variant_t var_sel, input logic [2:0] i);
    logic [63:0] v;
    unique case (var_sel)
      VAR_224: v = {32'h0, iv_384(i)[31:0]};
      VAR_256: v = {32'h0, iv_512(i)[63:32]};
      VAR_384: v = iv_384(i);
      default: v = iv_512(i);
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== design/sha2_stream_if.sv =====
// interfaces: valid/ready channels for message words and digest words
`default_nettype none
interface sha2_msg_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic [3:0]  valid_bytes;
  logic        last_word;
  modport source (output valid, message_word, valid_bytes, last_word, input ready);
  modport sink (input valid, message_word, valid_bytes, last_word, output ready);
endinterface

interface sha2_dig_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic        digest_last;
  modport source (output valid, digest_word, digest_last, input ready);
  modport sink (input valid, digest_word, digest_last, output ready);
endinterface
`default_nettype wire

// ===== design/sha2_round.sv =====
// round unit: working variables, message schedule and one shared round datapath
`default_nettype none
module sha2_round (
  input  wire logic              clk,
  input  wire sha2_pkg::rnd_ctl_t ctl,
  input  wire logic [63:0]       blk_in [16],
  input  wire logic [63:0]       hash_in [8],
  output logic [63:0]            hash_sum [8]
);

  logic [63:0] v_r [8];
  logic [63:0] w_r [16];
  logic [63:0] mask, wt, kt, s0, s1, e1, e0, ch, maj, t1, t2, a, b;
  logic [63:0] a_n, e_n;

  // rotate within 32 or 64 bits
  function automatic logic [63:0] rotr(input logic [63:0] x, input int n, input logic wd);
    logic [63:0] r;
    logic [31:0] x32;
    x32 = x[31:0];
    if (wd) r = (x >> n) | (x << (64 - n));
    else r = {32'h0, (x32 >> (n % 32)) | (x32 << ((32 - n) % 32))};
    return r;
  endfunction

  function automatic logic [63:0] round_k_sel(input logic wd);
    logic [63:0] k;
    k = sha2_pkg::round_k(ctl.rnd);
    return wd ? k : {32'h0, k[63:32]};
  endfunction

  // schedule word for this round
  always_comb begin
    mask = ctl.wide ? 64'hffff_ffff_ffff_ffff : 64'h0000_0000_ffff_ffff;
    a = w_r[1];
    b = w_r[14];
    if (ctl.wide) begin
      s0 = rotr(a, 1, 1'b1) ^ rotr(a, 8, 1'b1) ^ (a >> 7);
      s1 = rotr(b, 19, 1'b1) ^ rotr(b, 61, 1'b1) ^ (b >> 6);
    end else begin
      s0 = rotr(a, 7, 1'b0) ^ rotr(a, 18, 1'b0) ^ (a >> 3);
      s1 = rotr(b, 17, 1'b0) ^ rotr(b, 19, 1'b0) ^ (b >> 10);
    end
    wt = (ctl.rnd < 7'd16) ? w_r[0] : ((s1 + w_r[9] + s0 + w_r[0]) & mask);
    kt = ctl.wide ? round_k_sel(1'b1) : round_k_sel(1'b0);
  end

  // compression round
  always_comb begin
    if (ctl.wide) begin
      e1 = rotr(v_r[4], 14, 1'b1) ^ rotr(v_r[4], 18, 1'b1) ^ rotr(v_r[4], 41, 1'b1);
      e0 = rotr(v_r[0], 28, 1'b1) ^ rotr(v_r[0], 34, 1'b1) ^ rotr(v_r[0], 39, 1'b1);
    end else begin
      e1 = rotr(v_r[4], 6, 1'b0) ^ rotr(v_r[4], 11, 1'b0) ^ rotr(v_r[4], 25, 1'b0);
      e0 = rotr(v_r[0], 2, 1'b0) ^ rotr(v_r[0], 13, 1'b0) ^ rotr(v_r[0], 22, 1'b0);
    end
    ch  = v_r[6] ^ (v_r[4] & (v_r[5] ^ v_r[6]));
    maj = (v_r[0] & v_r[1]) | (v_r[2] & (v_r[0] | v_r[1]));
    t1  = (v_r[7] + e1 + ch + kt + wt) & mask;
    t2  = (e0 + maj) & mask;
    a_n = (t1 + t2) & mask;
    e_n = (v_r[3] + t1) & mask;
    for (int i = 0; i < 8; i++) hash_sum[i] = (hash_in[i] + v_r[i]) & mask;
  end

  // working variables and a sliding 16-word schedule window
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      v_r <= hash_in;
      w_r <= blk_in;
    end else if (ctl.step) begin
      v_r[0] <= a_n; v_r[1] <= v_r[0]; v_r[2] <= v_r[1]; v_r[3] <= v_r[2];
      v_r[4] <= e_n; v_r[5] <= v_r[4]; v_r[6] <= v_r[5]; v_r[7] <= v_r[6];
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
      w_r[15] <= wt;
    end
  end

endmodule
`default_nettype wire

// ===== design/sha2_hash_engine.sv =====
// top level: sha-2 engine with block buffer, padding sequencer and apb config
//
// channel  dir  handshake        payload
// in_      in   in_valid/ready   message_word, valid_bytes, last_word
// out_     out  out_valid/ready  digest_word, digest_last
// cfg_     in   apb write        hash_variant at address 0
//
// a non-last word is only buffered, unless it completes a block, which then runs
// through accept, working-variable load, one round per cycle in the shared unit, and fold
// a last word runs one or two padded blocks (the idle state builds the second block),
// then streams 6 to 8 digest words, one per cycle while out_ready is high
// rst_n is synchronous; reset loads the sha-256 initial hash
// in_ready is low from a block start until its fold, or until the last digest transaction
`default_nettype none
module sha2_hash_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  sha2_msg_if.sink         in_ch,
  sha2_dig_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  sha2_pkg::state_t   state_r, state_nxt;
  sha2_pkg::variant_t var_r;
  sha2_pkg::rnd_ctl_t ctl;
  logic [63:0] hash_r [8];
  logic [63:0] blk_r [16];
  logic [63:0] hash_sum [8];
  logic [4:0]  fill_r;
  logic [63:0] len_lo_r, len_hi_r;
  logic [6:0]  rnd_r;
  logic        final_r;   // padding pending after this block
  logic        pad_r;     // 0x80 still to be placed
  logic        mid_blk_r; // block in flight is not the last of its message
  logic [2:0]  emit_r;
  logic        wide, cfg_wr, acc, rnd_end, start, fits;
  logic [63:0] mask, word, bits_add, len_sum;
  logic [3:0]  vb, wb;
  logic [2:0]  cnt_last;

  assign wide    = (var_r == sha2_pkg::VAR_384) || (var_r == sha2_pkg::VAR_512);
  assign mask    = wide ? 64'hffff_ffff_ffff_ffff : 64'h0000_0000_ffff_ffff;
  assign wb      = wide ? 4'd8 : 4'd4;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == sha2_pkg::REG_VARIANT;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {30'h0, var_r};
  assign acc     = in_ch.valid && in_ch.ready;
  assign rnd_end = rnd_r == (wide ? 7'd79 : 7'd63);
  assign cnt_last = (var_r == sha2_pkg::VAR_224) ? 3'd6 :
                    (var_r == sha2_pkg::VAR_384) ? 3'd5 : 3'd7;

  // padded word and bit count for an accepted word
  always_comb begin
    vb = in_ch.last_word ? ((in_ch.valid_bytes > wb) ? wb : in_ch.valid_bytes) : wb;
    word = in_ch.message_word & mask;
    if (in_ch.last_word && vb < wb) begin
      word = (word & (mask << {(wb - vb), 3'b000})) |
             ({56'h0, sha2_pkg::PAD_BYTE} << {(wb - vb - 4'd1), 3'b000});
    end
    bits_add = {57'h0, vb, 3'b000};
    len_sum  = len_lo_r + bits_add;
  end

  // length still fits in the block that holds the last word
  assign fits = fill_r < 5'd13 || (fill_r == 5'd13 && vb < wb);

  // round unit loads in the cycle after a block start, once the buffer is written
  assign ctl.load = state_r == sha2_pkg::ST_LOAD;
  assign ctl.step = state_r == sha2_pkg::ST_ROUND;
  assign ctl.wide = wide;
  assign ctl.rnd  = rnd_r;

  sha2_round u_round (
    .clk(clk), .ctl(ctl), .blk_in(blk_r), .hash_in(hash_r), .hash_sum(hash_sum)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sha2_pkg::ST_IDLE:  if (start) state_nxt = sha2_pkg::ST_LOAD;
      sha2_pkg::ST_LOAD:  state_nxt = sha2_pkg::ST_ROUND;
      sha2_pkg::ST_ROUND: if (rnd_end) state_nxt = sha2_pkg::ST_FINAL;
      sha2_pkg::ST_FINAL: state_nxt = (final_r || mid_blk_r) ? sha2_pkg::ST_IDLE
                                                              : sha2_pkg::ST_EMIT;
      sha2_pkg::ST_EMIT:  if (out_ch.ready && emit_r == cnt_last) state_nxt = sha2_pkg::ST_IDLE;
      default:            state_nxt = sha2_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready = (state_r == sha2_pkg::ST_IDLE) && !final_r;
    out_ch.valid = state_r == sha2_pkg::ST_EMIT;
    out_ch.digest_word = hash_r[emit_r] & mask;
    out_ch.digest_last = emit_r == cnt_last;
  end

  // block start: a full buffer, a last word, or a padding block still pending
  assign start = (acc && (fill_r == 5'd15 || in_ch.last_word)) ||
                 (state_r == sha2_pkg::ST_IDLE && final_r);

  // message buffer, length and padding sequencing
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr || (state_r == sha2_pkg::ST_EMIT && state_nxt == sha2_pkg::ST_IDLE)) begin
      if (!rst_n) var_r <= sha2_pkg::VAR_256;
      else if (cfg_wr) var_r <= sha2_pkg::variant_t'(cfg_pwdata[1:0]);
      for (int i = 0; i < 8; i++)
        hash_r[i] <= sha2_pkg::init_hash(!rst_n ? sha2_pkg::VAR_256 :
                     cfg_wr ? sha2_pkg::variant_t'(cfg_pwdata[1:0]) : var_r, 3'(i));
      fill_r   <= '0;
      len_lo_r <= '0;
      len_hi_r <= '0;
      final_r  <= 1'b0;
      pad_r    <= 1'b0;
      emit_r   <= '0;
      rnd_r    <= '0;
      state_r  <= sha2_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
      if (acc) begin
        len_lo_r <= len_sum;
        if (len_sum < len_lo_r) len_hi_r <= len_hi_r + 64'd1;
        blk_r[fill_r[3:0]] <= word;
        if (in_ch.last_word) begin
          // build the tail in the buffer directly where it fits
          pad_r <= (vb == wb) && (fill_r == 5'd15);
          for (int i = 0; i < 16; i++) begin
            if (5'(i) > fill_r && !(fits && i >= 14)) begin
              blk_r[i] <= (vb == wb && 5'(i) == fill_r + 5'd1) ?
                          ({56'h0, sha2_pkg::PAD_BYTE} << {(wb - 4'd1), 3'b000}) : 64'h0;
            end
          end
          if (fits) begin
            blk_r[14] <= wide ? len_hi_r + {63'h0, len_sum < len_lo_r} : {32'h0, len_sum[63:32]};
            blk_r[15] <= wide ? len_sum : {32'h0, len_sum[31:0]};
            final_r <= 1'b0;
            emit_r <= '0;
          end else begin
            final_r <= 1'b1;
          end
          fill_r <= '0;
        end else begin
          fill_r <= (fill_r == 5'd15) ? 5'd0 : fill_r + 5'd1;
        end
      end
      if (state_r == sha2_pkg::ST_ROUND) rnd_r <= rnd_end ? 7'd0 : rnd_r + 7'd1;
      if (state_r == sha2_pkg::ST_FINAL) hash_r <= hash_sum;
      // second padded block after a block that had no room for the length
      if (state_r == sha2_pkg::ST_IDLE && final_r) begin
        final_r <= 1'b0;
        for (int i = 0; i < 14; i++)
          blk_r[i] <= (pad_r && i == 0) ? ({56'h0, sha2_pkg::PAD_BYTE} << {(wb - 4'd1), 3'b000})
                                        : 64'h0;
        blk_r[14] <= wide ? len_hi_r : {32'h0, len_lo_r[63:32]};
        blk_r[15] <= wide ? len_lo_r : {32'h0, len_lo_r[31:0]};
        pad_r <= 1'b0;
        emit_r <= '0;
      end
      if (state_r == sha2_pkg::ST_EMIT && out_ch.ready) emit_r <= emit_r + 3'd1;
    end
  end

  // final block of a message leads to emission; a middle block, or the first of two padded blocks, returns idle
  always_ff @(posedge clk) begin
    if (!rst_n) mid_blk_r <= 1'b1;
    else if (start) mid_blk_r <= acc && !in_ch.last_word;
  end

  // assertions
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid) else $error("ready while emitting");
  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> emit_r <= cnt_last) else $error("digest index out of range");
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    !wide |-> rnd_r < 7'd64) else $error("round past 63 in narrow mode");
  a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha2_pkg::ST_ROUND) |-> !acc) else $error("word taken during rounds");

  logic unused_ok;
  assign unused_ok = ^cfg_pwdata[31:2];

endmodule
`default_nettype wire

// ===== tb/sha2_hash_engine_test.sv =====
// testbench: sha-2 engine driven with directed and random messages, digests checked by a predictor
`default_nettype none
module sha2_hash_engine_test;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEM_TARGET = 410;
  localparam logic [63:0] M32 = 64'h0000_0000_ffff_ffff;

  localparam logic [63:0] RND_CONST [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };
  localparam logic [63:0] START_384 [8] = '{
    64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
    64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
  };
  localparam logic [63:0] START_512 [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  // digest predictor and store of expected digest words
  class sha2_scoreboard;
    sha2_pkg::variant_t variant;
    logic [63:0] chain [8];
    logic [63:0] block [16];
    int          fill;
    logic [63:0] bits_lo, bits_hi;
    logic [63:0] digest_q [$];
    logic        last_q [$];
    int          errors;

    function new();
      variant = sha2_pkg::VAR_256;
      errors = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) begin
        case (variant)
          sha2_pkg::VAR_224: chain[i] = START_384[i] & M32;
          sha2_pkg::VAR_256: chain[i] = START_512[i] >> 32;
          sha2_pkg::VAR_384: chain[i] = START_384[i];
          default: chain[i] = START_512[i];
        endcase
      end
      fill = 0;
      bits_lo = '0;
      bits_hi = '0;
    endfunction

    function void set_variant(sha2_pkg::variant_t v);
      variant = v;
      restart();
    endfunction

    function logic [63:0] rotr(logic [63:0] x, int n, bit wide);
      if (wide) return (x >> n) | (x << (64 - n));
      x = x & M32;
      return ((x >> n) | (x << (32 - n))) & M32;
    endfunction

    function void compress(bit wide);
      logic [63:0] w [16];
      logic [63:0] v [8];
      logic [63:0] mask, t1, t2, s0, s1, a, b, kt;
      int rounds;
      mask = wide ? '1 : M32;
      rounds = wide ? 80 : 64;
      w = block;
      v = chain;
      for (int t = 0; t < rounds; t++) begin
        // message schedule in a 16-word ring
        if (t >= 16) begin
          a = w[(t - 15) & 15];
          b = w[(t - 2) & 15];
          if (wide) begin
            s0 = rotr(a, 1, 1) ^ rotr(a, 8, 1) ^ (a >> 7);
            s1 = rotr(b, 19, 1) ^ rotr(b, 61, 1) ^ (b >> 6);
          end else begin
            s0 = rotr(a, 7, 0) ^ rotr(a, 18, 0) ^ (a >> 3);
            s1 = rotr(b, 17, 0) ^ rotr(b, 19, 0) ^ (b >> 10);
          end
          w[t & 15] = (s1 + w[(t - 7) & 15] + s0 + w[t & 15]) & mask;
        end
        kt = wide ? RND_CONST[t] : (RND_CONST[t] >> 32);
        if (wide) begin
          s1 = rotr(v[4], 14, 1) ^ rotr(v[4], 18, 1) ^ rotr(v[4], 41, 1);
          s0 = rotr(v[0], 28, 1) ^ rotr(v[0], 34, 1) ^ rotr(v[0], 39, 1);
        end else begin
          s1 = rotr(v[4], 6, 0) ^ rotr(v[4], 11, 0) ^ rotr(v[4], 25, 0);
          s0 = rotr(v[0], 2, 0) ^ rotr(v[0], 13, 0) ^ rotr(v[0], 22, 0);
        end
        t1 = (v[7] + s1 + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + kt + w[t & 15]) & mask;
        t2 = (s0 + ((v[0] & v[1]) | (v[2] & (v[0] | v[1])))) & mask;
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
        v[4] = (v[3] + t1) & mask;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
        v[0] = (t1 + t2) & mask;
      end
      for (int i = 0; i < 8; i++) chain[i] = (chain[i] + v[i]) & mask;
    endfunction

    function void push(logic [63:0] word, bit wide);
      block[fill] = word;
      fill++;
      if (fill >= 16) begin
        compress(wide);
        fill = 0;
      end
    endfunction

    function void add_bits(logic [63:0] n);
      logic [63:0] sum;
      sum = bits_lo + n;
      if (sum < bits_lo) bits_hi++;
      bits_lo = sum;
    endfunction

    // accepted message word: absorb, and on the last one pad and queue the digest
    function void note_word(logic [63:0] word_in, logic [3:0] vb, logic last);
      bit          wide;
      int          wb, nv, low, count;
      logic [63:0] mask, word, keep;
      wide = (variant == sha2_pkg::VAR_384) || (variant == sha2_pkg::VAR_512);
      wb = wide ? 8 : 4;
      mask = wide ? '1 : M32;
      word = word_in & mask;
      if (!last) begin
        add_bits(wb * 8);
        push(word, wide);
        return;
      end
      nv = (vb > wb) ? wb : vb;
      add_bits(nv * 8);
      if (nv < wb) begin
        low = (wb - nv) * 8;
        keep = (low >= 64) ? '0 : (mask & ~((64'd1 << low) - 64'd1));
        push((word & keep) | (64'h80 << (low - 8)), wide);
      end else begin
        push(word, wide);
        push(64'h80 << (wb * 8 - 8), wide);
      end
      // no room for the length: pad out and add one block
      if (fill > 14) begin
        while (fill < 16) block[fill++] = '0;
        compress(wide);
        fill = 0;
      end
      while (fill < 14) block[fill++] = '0;
      if (wide) begin
        block[14] = bits_hi;
        block[15] = bits_lo;
      end else begin
        block[14] = bits_lo >> 32;
        block[15] = bits_lo & M32;
      end
      compress(wide);
      case (variant)
        sha2_pkg::VAR_224: count = 7;
        sha2_pkg::VAR_384: count = 6;
        default: count = 8;
      endcase
      for (int i = 0; i < count; i++) begin
        digest_q.push_back(chain[i] & mask);
        last_q.push_back(i == count - 1);
      end
      restart();
    endfunction

    function void check_digest(logic [63:0] word, logic last);
      logic [63:0] ew;
      logic        el;
      if (digest_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected digest transaction %h last %b", word, last);
        return;
      end
      ew = digest_q.pop_front();
      el = last_q.pop_front();
      if (ew !== word || el !== last) begin
        errors++;
        if (errors <= 10)
          $display("digest mismatch: expected %h last %b, got %h last %b", ew, el, word, last);
      end
    endfunction

    function int pending();
      return digest_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  sha2_msg_if  msg ();
  sha2_dig_if  dig ();

  sha2_scoreboard sb = new();
  int cycles = 0;
  int items = 0;
  int stall_left = 0;
  bit calm = 0;

  sha2_hash_engine i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(msg), .out_ch(dig),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // digest sink: check each transaction, stall at random
  always @(posedge clk) begin
    if (rst_n && dig.valid && dig.ready) sb.check_digest(dig.digest_word, dig.digest_last);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      dig.ready <= 1'b0;
    end else begin
      stall_left <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
      dig.ready <= 1'b1;
    end
  end

  task automatic send_word(logic [63:0] word, logic [3:0] vb, logic last);
    int gap;
    msg.valid <= 1'b1;
    msg.message_word <= word;
    msg.valid_bytes <= vb;
    msg.last_word <= last;
    do @(posedge clk); while (!msg.ready);
    sb.note_word(word, vb, last);
    items++;
    gap = pick_gap();
    if (gap > 0) begin
      msg.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // settle the engine, then write hash_variant through the apb port
  task automatic write_variant(sha2_pkg::variant_t v);
    msg.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 2'(4 * sha2_pkg::REG_VARIANT);
    cfg_pwdata <= {30'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.set_variant(v);
  endtask

  function logic [63:0] rand_word();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_message();
    int n, wb;
    wb = (sb.variant == sha2_pkg::VAR_384 || sb.variant == sha2_pkg::VAR_512) ? 8 : 4;
    calm = ($urandom_range(0, 4) == 0);
    n = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 20) : $urandom_range(14, 40);
    for (int i = 0; i < n; i++) send_word(rand_word(), 4'($urandom_range(0, 15)), 1'b0);
    if ($urandom_range(0, 9) == 0) send_word(rand_word(), 4'($urandom_range(0, 15)), 1'b1);
    else send_word(rand_word(), 4'($urandom_range(0, wb)), 1'b1);
  endtask

  initial begin
    sha2_pkg::variant_t phases [6];
    rst_n = 1'b0;
    msg.valid = 1'b0;
    msg.message_word = '0;
    msg.valid_bytes = '0;
    msg.last_word = 1'b0;
    dig.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty messages, oversized and full last words, two-block padding
    send_word(64'hffff_ffff_ffff_ffff, 4'd0, 1'b1);
    for (int i = 0; i < 14; i++) send_word(64'h0123_4567_89ab_cdef, 4'd4, 1'b0);
    send_word(64'hffff_ffff_ffff_ffff, 4'd0, 1'b1);
    write_variant(sha2_pkg::VAR_224);
    send_word(64'hffff_ffff_ffff_ffff, 4'd15, 1'b1);
    write_variant(sha2_pkg::VAR_512);
    send_word(64'hffff_ffff_ffff_ffff, 4'd8, 1'b1);
    send_word(64'h8000_0000_0000_0001, 4'd2, 1'b0);
    send_word(64'hfedc_ba98_7654_3210, 4'd3, 1'b1);
    // variant change abandons a message in progress
    send_word(64'h0, 4'd8, 1'b0);
    send_word(64'hffff_ffff_ffff_ffff, 4'd8, 1'b0);
    write_variant(sha2_pkg::VAR_384);
    send_word(64'h0, 4'd0, 1'b1);

    // random messages over several variant settings
    phases = '{sha2_pkg::VAR_384, sha2_pkg::VAR_256, sha2_pkg::VAR_512,
               sha2_pkg::VAR_224, sha2_pkg::VAR_512, sha2_pkg::VAR_256};
    for (int p = 0; p < 6; p++) begin
      if (p > 0) write_variant(phases[p]);
      while (items < 25 + (p + 1) * (ITEM_TARGET - 25) / 6) random_message();
    end

    msg.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
